// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/circ_pkg.sv =====
// ----------------------------------------------------------------------------
// circ_pkg
// Widths, payload types and status codes of the circumcircle pipeline.
// ----------------------------------------------------------------------------
package circ_pkg;

  localparam int CW    = 32;  // coordinate width
  localparam int DW    = 33;  // coordinate difference
  localparam int SQW   = 65;  // squared length
  localparam int PRW   = 66;  // 33x33 product, cross product
  localparam int NXW   = 99;  // center numerator, signed
  localparam int NMW   = 98;  // numerator magnitude
  localparam int DENW  = 66;  // 2*|cross|
  localparam int QB    = 35;  // quotient bits
  localparam int QMW   = 34;  // clipped quotient magnitude
  localparam int RW    = 33;  // root bits
  localparam int REMW  = 36;  // root remainder
  localparam int XW    = 36;  // center before clamp

  localparam logic [QMW-1:0] QLIM = {2'b10, {(QMW-2){1'b0}}};

  typedef enum logic [2:0] {
    ST_THREE = 3'd0,
    ST_DIAM  = 3'd1,
    ST_FEW   = 3'd2,
    ST_DEGEN = 3'd3,
    ST_SAT   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]           point_count;
    logic signed [CW-1:0] p0_x;
    logic signed [CW-1:0] p0_y;
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] p2_x;
    logic signed [CW-1:0] p2_y;
  } circ_in_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [CW-1:0]        radius;
    logic [2:0]           status;
  } circ_out_t;

  // sideband that rides along the divider and root stages
  typedef struct packed {
    status_e         kind;
    logic            neg_x;
    logic            neg_y;
    logic            big;
    logic [XW-1:0]   cx;
    logic [XW-1:0]   cy;
    logic [SQW-1:0]  d2;
  } side_t;

endpackage

// ===== rtl/circumcircle_from_points.sv =====
// Stages from accepted input beat to output beat: 7 front stages,
// 37 divider stages, 3 offset/square stages, 34 root stages, output register.
// Throughput: one beat per unstalled cycle; one bit per divider/root stage.
// Stall: the whole pipeline holds while a finished beat waits at the output.
// Reset: pipeline valids and the output valid clear; tolerance resets to 1.
// ----------------------------------------------------------------------------
// circumcircle_from_points
// Circle through up to three Q16.16 points, fully pipelined.
// ----------------------------------------------------------------------------
module circumcircle_from_points import circ_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  circ_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output circ_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

`include "assert_macros.svh"

  logic [15:0]   tol_q;
  logic [CW-1:0] tol2;
  logic          en;
  logic          out_valid_q;
  circ_out_t     out_q, out_d;

  assign tol2       = {16'h0000, tol_q} * {16'h0000, tol_q};
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 16'd1;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  logic            fv;
  logic [NMW-1:0]  fnx, fny;
  logic [DENW-1:0] fden;
  side_t           fside;

  circ_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .data_i(in_data_i),
    .tol2_i(tol2), .valid_o(fv), .nmag_x_o(fnx), .nmag_y_o(fny),
    .den_o(fden), .side_o(fside)
  );

  logic           dv;
  logic [QMW-1:0] dqx, dqy;
  side_t          dside;

  circ_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv), .nmag_x_i(fnx), .nmag_y_i(fny),
    .den_i(fden), .side_i(fside), .valid_o(dv), .q_x_o(dqx), .q_y_o(dqy),
    .side_o(dside)
  );

  // offset, center, squares of the offset, root operand
  logic [2:0]      pv_q;
  side_t           p1s_q, p2s_q, p3s_q;
  logic [CW-1:0]   p1qx_q, p1qy_q;
  logic [2*CW-1:0] sqx_q, sqy_q;
  logic [SQW-1:0]  s3_q;
  logic [QMW:0]    oxe, oye, oxn, oyn;
  side_t           p1s_d;

  always_comb begin
    oxe   = {1'b0, dqx};
    oye   = {1'b0, dqy};
    oxn   = dside.neg_x ? (~oxe + 1'b1) : oxe;
    oyn   = dside.neg_y ? (~oye + 1'b1) : oye;
    p1s_d = dside;
    if (dside.kind == ST_THREE) begin
      p1s_d.cx  = dside.cx + {oxn[QMW], oxn};
      p1s_d.cy  = dside.cy + {oyn[QMW], oyn};
      p1s_d.big = (dqx[QMW-1:CW] != '0) || (dqy[QMW-1:CW] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[1:0], dv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1s_q  <= p1s_d;
      p1qx_q <= dqx[CW-1:0];
      p1qy_q <= dqy[CW-1:0];
      p2s_q  <= p1s_q;
      sqx_q  <= p1qx_q * p1qx_q;
      sqy_q  <= p1qy_q * p1qy_q;
      p3s_q  <= p2s_q;
      s3_q   <= (p2s_q.kind == ST_DIAM) ? p2s_q.d2 : ({1'b0, sqx_q} + {1'b0, sqy_q});
    end
  end

  logic            rv;
  logic [RW-1:0]   root;
  logic [REMW-1:0] rem;
  side_t           rside;

  circ_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pv_q[2]), .s_i(s3_q), .side_i(p3s_q),
    .valid_o(rv), .root_o(root), .rem_o(rem), .side_o(rside)
  );

  // final rounding, clamping and status
  logic [RW:0]   rad3, radd, rad;
  logic          rsat, xsat, ysat;
  logic [CW-1:0] cxc, cyc;

  function automatic logic [CW-1:0] clamp36(input logic [XW-1:0] v, output logic sat);
    logic hi, lo;
    hi  = !v[XW-1] && (v[XW-2:CW-1] != '0);
    lo  = v[XW-1] && (v[XW-2:CW-1] != '1);
    sat = hi || lo;
    if (hi) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (lo) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return v[CW-1:0];
  endfunction

  always_comb begin
    rad3  = {1'b0, root} + {{RW{1'b0}}, (rem > {{(REMW-RW){1'b0}}, root})};
    radd  = ({1'b0, root} + 1'b1) >> 1;
    rad   = (rside.kind == ST_THREE) ? rad3 : radd;
    rsat  = rside.big || rad[RW:CW] != '0;
    cxc   = clamp36(rside.cx, xsat);
    cyc   = clamp36(rside.cy, ysat);
    out_d = '0;
    if (rside.kind == ST_FEW || rside.kind == ST_DEGEN) begin
      out_d.status = rside.kind;
    end else begin
      out_d.center_x = cxc;
      out_d.center_y = cyc;
      out_d.radius   = rsat ? {CW{1'b1}} : rad[CW-1:0];
      out_d.status   = (rsat || xsat || ysat) ? ST_SAT : rside.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMP(a_stall_only_when_full, !out_valid_q, !in_stall_o,
    "input stalled with empty output register")
  `ASSERT_IMP(a_fail_zero,
    out_valid_q && (out_q.status == ST_FEW || out_q.status == ST_DEGEN),
    out_q.center_x == '0 && out_q.center_y == '0 && out_q.radius == '0,
    "failed beat carries nonzero geometry")
  `ASSERT_IMP(a_sat_clipped, out_valid_q && out_q.status == ST_SAT,
    out_q.radius == '1 || out_q.center_x == {1'b0, {(CW-1){1'b1}}} ||
    out_q.center_x == {1'b1, {(CW-1){1'b0}}} || out_q.center_y == {1'b0, {(CW-1){1'b1}}} ||
    out_q.center_y == {1'b1, {(CW-1){1'b0}}},
    "saturated status without a clipped field")
  `ASSERT_NXT(a_hold_pipe, out_valid_q && out_stall_i, out_valid_q && $stable(out_q),
    "stalled output beat changed")

endmodule

// ===== rtl/circ_front.sv =====
// ----------------------------------------------------------------------------
// circ_front
// Seven stages: edge vectors, squares and cross terms, classification,
// split products and center numerators with their magnitudes.
// ----------------------------------------------------------------------------
module circ_front import circ_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  circ_in_t        data_i,
  input  logic [CW-1:0]   tol2_i,
  output logic            valid_o,
  output logic [NMW-1:0]  nmag_x_o,
  output logic [NMW-1:0]  nmag_y_o,
  output logic [DENW-1:0] den_o,
  output side_t           side_o
);

  logic [6:0] v_q;

  // stage 1
  logic [1:0]            cnt1_q;
  logic [CW-1:0]         x01_q, y01_q;
  logic signed [DW-1:0]  ax1_q, ay1_q, bx1_q, by1_q, dx1_q, dy1_q, sx1_q, sy1_q;
  // stage 2
  logic [1:0]            cnt2_q;
  logic [CW-1:0]         x02_q, y02_q, cdx2_q, cdy2_q;
  logic signed [DW-1:0]  ax2_q, ay2_q, bx2_q, by2_q;
  logic signed [PRW-1:0] axx_q, ayy_q, bxx_q, byy_q, dxx_q, dyy_q, axby_q, aybx_q;
  // stage 3
  logic [1:0]            cnt3_q;
  logic [CW-1:0]         x03_q, y03_q, cdx3_q, cdy3_q;
  logic signed [DW-1:0]  ax3_q, ay3_q, bx3_q, by3_q;
  logic [SQW-1:0]        a3_q, b3_q, d3_q;
  logic signed [PRW-1:0] cr3_q;
  // stage 4
  side_t                 s4_q;
  logic                  crneg4_q;
  logic [DENW-1:0]       den4_q;
  logic signed [PRW-1:0] pal_by_q, pbl_ay_q, pbl_ax_q, pal_bx_q;
  logic signed [PRW:0]   pah_by_q, pbh_ay_q, pbh_ax_q, pah_bx_q;
  // stage 5
  side_t                 s5_q;
  logic                  crneg5_q;
  logic [DENW-1:0]       den5_q;
  logic [NXW-1:0]        ta_q, tb_q, tc_q, td_q;
  // stage 6
  side_t                 s6_q, s6_d;
  logic [DENW-1:0]       den6_q;
  logic [NXW-1:0]        nx6_q, ny6_q;
  // stage 7
  side_t                 s7_q, s7_d;
  logic [DENW-1:0]       den7_q;
  logic [NMW-1:0]        nmx7_q, nmy7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // half of p0+p1, rounded away from zero on ties
  function automatic logic [CW-1:0] half_round(input logic [DW-1:0] s);
    logic [DW:0] mag;
    logic [DW:0] h;
    logic [DW:0] hn;
    mag = s[DW-1] ? (~{s[DW-1], s} + 1'b1) : {1'b0, s};
    h   = (mag + 1'b1) >> 1;
    hn  = ~h + 1'b1;
    return s[DW-1] ? hn[CW-1:0] : h[CW-1:0];
  endfunction

  // classification of stage 3 contents
  logic            few3, diam3, degd3, degt3;
  logic [SQW-1:0]  abscr3;
  logic [PRW-1:0]  crn3;
  status_e         kind3;

  always_comb begin
    crn3   = ~cr3_q + 1'b1;
    abscr3 = cr3_q[PRW-1] ? crn3[SQW-1:0] : cr3_q[SQW-1:0];
    few3   = (cnt3_q < 2'd2);
    diam3  = (cnt3_q == 2'd2) || (d3_q < {{(SQW-CW){1'b0}}, tol2_i});
    degd3  = a3_q <= {{(SQW-CW-2){1'b0}}, tol2_i, 2'b00};
    degt3  = (cr3_q == '0) || (abscr3 < {{(SQW-CW){1'b0}}, tol2_i});
    if (few3) begin
      kind3 = ST_FEW;
    end else if (diam3) begin
      kind3 = degd3 ? ST_DEGEN : ST_DIAM;
    end else begin
      kind3 = degt3 ? ST_DEGEN : ST_THREE;
    end
  end

  logic [NXW-1:0] nx6n, ny6n;
  assign nx6n = ~nx6_q + 1'b1;
  assign ny6n = ~ny6_q + 1'b1;

  always_comb begin
    // cross sign kept in neg_y until the numerators exist
    s6_d       = s5_q;
    s6_d.neg_y = crneg5_q;
    // quotient sign
    s7_d       = s6_q;
    s7_d.neg_x = nx6_q[NXW-1] ^ s6_q.neg_y;
    s7_d.neg_y = ny6_q[NXW-1] ^ s6_q.neg_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1
      cnt1_q <= data_i.point_count;
      x01_q  <= data_i.p0_x;
      y01_q  <= data_i.p0_y;
      ax1_q  <= {data_i.p1_x[CW-1], data_i.p1_x} - {data_i.p0_x[CW-1], data_i.p0_x};
      ay1_q  <= {data_i.p1_y[CW-1], data_i.p1_y} - {data_i.p0_y[CW-1], data_i.p0_y};
      bx1_q  <= {data_i.p2_x[CW-1], data_i.p2_x} - {data_i.p0_x[CW-1], data_i.p0_x};
      by1_q  <= {data_i.p2_y[CW-1], data_i.p2_y} - {data_i.p0_y[CW-1], data_i.p0_y};
      dx1_q  <= {data_i.p2_x[CW-1], data_i.p2_x} - {data_i.p1_x[CW-1], data_i.p1_x};
      dy1_q  <= {data_i.p2_y[CW-1], data_i.p2_y} - {data_i.p1_y[CW-1], data_i.p1_y};
      sx1_q  <= {data_i.p0_x[CW-1], data_i.p0_x} + {data_i.p1_x[CW-1], data_i.p1_x};
      sy1_q  <= {data_i.p0_y[CW-1], data_i.p0_y} + {data_i.p1_y[CW-1], data_i.p1_y};
      // stage 2
      cnt2_q <= cnt1_q;
      x02_q  <= x01_q;
      y02_q  <= y01_q;
      cdx2_q <= half_round(sx1_q);
      cdy2_q <= half_round(sy1_q);
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      bx2_q  <= bx1_q;
      by2_q  <= by1_q;
      axx_q  <= ax1_q * ax1_q;
      ayy_q  <= ay1_q * ay1_q;
      bxx_q  <= bx1_q * bx1_q;
      byy_q  <= by1_q * by1_q;
      dxx_q  <= dx1_q * dx1_q;
      dyy_q  <= dy1_q * dy1_q;
      axby_q <= ax1_q * by1_q;
      aybx_q <= ay1_q * bx1_q;
      // stage 3
      cnt3_q <= cnt2_q;
      x03_q  <= x02_q;
      y03_q  <= y02_q;
      cdx3_q <= cdx2_q;
      cdy3_q <= cdy2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      bx3_q  <= bx2_q;
      by3_q  <= by2_q;
      a3_q   <= SQW'(axx_q + ayy_q);
      b3_q   <= SQW'(bxx_q + byy_q);
      d3_q   <= SQW'(dxx_q + dyy_q);
      cr3_q  <= axby_q - aybx_q;
      // stage 4: split products, 32 low bits and the rest
      s4_q.kind  <= kind3;
      s4_q.neg_x <= 1'b0;
      s4_q.neg_y <= 1'b0;
      s4_q.big   <= 1'b0;
      s4_q.cx    <= (kind3 == ST_THREE) ? {{(XW-CW){x03_q[CW-1]}}, x03_q}
                                        : {{(XW-CW){cdx3_q[CW-1]}}, cdx3_q};
      s4_q.cy    <= (kind3 == ST_THREE) ? {{(XW-CW){y03_q[CW-1]}}, y03_q}
                                        : {{(XW-CW){cdy3_q[CW-1]}}, cdy3_q};
      s4_q.d2    <= a3_q;
      crneg4_q   <= cr3_q[PRW-1];
      den4_q     <= {abscr3, 1'b0};
      pal_by_q   <= $signed({1'b0, a3_q[CW-1:0]}) * by3_q;
      pah_by_q   <= $signed({1'b0, a3_q[SQW-1:CW]}) * by3_q;
      pbl_ay_q   <= $signed({1'b0, b3_q[CW-1:0]}) * ay3_q;
      pbh_ay_q   <= $signed({1'b0, b3_q[SQW-1:CW]}) * ay3_q;
      pbl_ax_q   <= $signed({1'b0, b3_q[CW-1:0]}) * ax3_q;
      pbh_ax_q   <= $signed({1'b0, b3_q[SQW-1:CW]}) * ax3_q;
      pal_bx_q   <= $signed({1'b0, a3_q[CW-1:0]}) * bx3_q;
      pah_bx_q   <= $signed({1'b0, a3_q[SQW-1:CW]}) * bx3_q;
      // stage 5
      s5_q     <= s4_q;
      crneg5_q <= crneg4_q;
      den5_q   <= den4_q;
      ta_q     <= {pah_by_q, {CW{1'b0}}} + {{(NXW-PRW){pal_by_q[PRW-1]}}, pal_by_q};
      tb_q     <= {pbh_ay_q, {CW{1'b0}}} + {{(NXW-PRW){pbl_ay_q[PRW-1]}}, pbl_ay_q};
      tc_q     <= {pbh_ax_q, {CW{1'b0}}} + {{(NXW-PRW){pbl_ax_q[PRW-1]}}, pbl_ax_q};
      td_q     <= {pah_bx_q, {CW{1'b0}}} + {{(NXW-PRW){pal_bx_q[PRW-1]}}, pal_bx_q};
      // stage 6
      s6_q     <= s6_d;
      den6_q   <= den5_q;
      nx6_q    <= ta_q - tb_q;
      ny6_q    <= tc_q - td_q;
      // stage 7: magnitudes and quotient sign
      s7_q     <= s7_d;
      den7_q   <= den6_q;
      nmx7_q   <= nx6_q[NXW-1] ? nx6n[NMW-1:0] : nx6_q[NMW-1:0];
      nmy7_q   <= ny6_q[NXW-1] ? ny6n[NMW-1:0] : ny6_q[NMW-1:0];
    end
  end

  assign valid_o  = v_q[6];
  assign nmag_x_o = nmx7_q;
  assign nmag_y_o = nmy7_q;
  assign den_o    = den7_q;
  assign side_o   = s7_q;

endmodule

// ===== rtl/circ_div.sv =====
// ----------------------------------------------------------------------------
// circ_div
// Two-lane restoring divider, one quotient bit per stage, shared divisor,
// then round to nearest and clip to 2^33.
// ----------------------------------------------------------------------------
module circ_div import circ_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NMW-1:0]  nmag_x_i,
  input  logic [NMW-1:0]  nmag_y_i,
  input  logic [DENW-1:0] den_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [QMW-1:0]  q_x_o,
  output logic [QMW-1:0]  q_y_o,
  output side_t           side_o
);

  logic [QB+1:0]    v_q;
  logic [DENW-1:0]  rem_q [QB+1][2];
  logic [QB-1:0]    low_q [QB+1][2];
  logic [QB-1:0]    quo_q [QB+1][2];
  logic             ovf_q [QB+1][2];
  logic [DENW-1:0]  den_q [QB+1];
  side_t            side_q [QB+1];

  logic [DENW:0]    cur_c [QB][2];
  logic [DENW:0]    sub_c [QB][2];
  logic             ge_c  [QB][2];

  logic [NMW-1:0]   nm_in [2];
  logic [QMW-1:0]   qout_c [2];
  logic [QMW-1:0]   qo_q [2];
  side_t            so_q;

  logic [DENW:0]    twice_c [2];
  logic [QB:0]      qr_c [2];

  assign nm_in[0] = nmag_x_i;
  assign nm_in[1] = nmag_y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QB:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < 2; l++) begin
        cur_c[k][l] = {rem_q[k][l], low_q[k][l][QB-1]};
        sub_c[k][l] = cur_c[k][l] - {1'b0, den_q[k]};
        ge_c[k][l]  = cur_c[k][l] >= {1'b0, den_q[k]};
      end
    end
    for (int l = 0; l < 2; l++) begin
      twice_c[l] = {rem_q[QB][l], 1'b0};
      qr_c[l]    = {1'b0, quo_q[QB][l]} +
                   {{QB{1'b0}}, (twice_c[l] >= {1'b0, den_q[QB]})};
      if (ovf_q[QB][l] || (qr_c[l] > {{(QB+1-QMW){1'b0}}, QLIM})) begin
        qout_c[l] = QLIM;
      end else begin
        qout_c[l] = qr_c[l][QMW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int l = 0; l < 2; l++) begin
        // quotient beyond 35 bits is clipped anyway
        ovf_q[0][l] <= {3'b000, nm_in[l]} >= {den_i, {QB{1'b0}}};
        rem_q[0][l] <= {{(DENW-NMW+QB){1'b0}}, nm_in[l][NMW-1:QB]};
        low_q[0][l] <= nm_in[l][QB-1:0];
        quo_q[0][l] <= '0;
      end
      for (int k = 0; k < QB; k++) begin
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
        for (int l = 0; l < 2; l++) begin
          ovf_q[k+1][l] <= ovf_q[k][l];
          rem_q[k+1][l] <= ge_c[k][l] ? sub_c[k][l][DENW-1:0] : cur_c[k][l][DENW-1:0];
          low_q[k+1][l] <= {low_q[k][l][QB-2:0], 1'b0};
          quo_q[k+1][l] <= {quo_q[k][l][QB-2:0], ge_c[k][l]};
        end
      end
      qo_q[0] <= qout_c[0];
      qo_q[1] <= qout_c[1];
      so_q    <= side_q[QB];
    end
  end

  assign valid_o = v_q[QB+1];
  assign q_x_o   = qo_q[0];
  assign q_y_o   = qo_q[1];
  assign side_o  = so_q;

endmodule

// ===== rtl/circ_sqrt.sv =====
// ----------------------------------------------------------------------------
// circ_sqrt
// Digit-by-digit integer square root, one root bit per stage. The final
// remainder is s - root^2.
// ----------------------------------------------------------------------------
module circ_sqrt import circ_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [SQW-1:0]  s_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [REMW-1:0] rem_o,
  output side_t           side_o
);

  logic [RW:0]     v_q;
  logic [REMW-1:0] rem_q  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [SQW:0]    rad_q  [RW+1];
  side_t           side_q [RW+1];

  logic [REMW-1:0] cur_c   [RW];
  logic [REMW-1:0] trial_c [RW];
  logic            ge_c    [RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RW-1:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < RW; k++) begin
      cur_c[k]   = {rem_q[k][REMW-3:0], rad_q[k][SQW:SQW-1]};
      trial_c[k] = {1'b0, root_q[k], 2'b01};
      ge_c[k]    = cur_c[k] >= trial_c[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rad_q[0]  <= {1'b0, s_i};
      side_q[0] <= side_i;
      for (int k = 0; k < RW; k++) begin
        rem_q[k+1]  <= ge_c[k] ? (cur_c[k] - trial_c[k]) : cur_c[k];
        root_q[k+1] <= {root_q[k][RW-2:0], ge_c[k]};
        rad_q[k+1]  <= {rad_q[k][SQW-2:0], 2'b00};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = root_q[RW];
  assign rem_o   = rem_q[RW];
  assign side_o  = side_q[RW];

endmodule
